// ===== design/rag_pkg.sv =====
// ----------------------------------------------------------------------------
// rag_pkg
// Types, command codes and the 5x7 font ROM of the rectangle and glyph blitter.
// ----------------------------------------------------------------------------
package rag_pkg;

	typedef enum logic [2:0] {
		KIND_CLEAR = 3'd0,
		KIND_FILL  = 3'd1,
		KIND_FRAME = 3'd2,
		KIND_GLYPH = 3'd3,
		KIND_READ  = 3'd4
	} kind_t;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic [11:0]        rect_w;
		logic [11:0]        rect_h;
		logic [7:0]         char_code;
		logic [15:0]        color;
		logic [15:0]        outline_color;
		logic [7:0]         scale_q4;
	} req_t;

	typedef struct packed {
		logic [15:0] read_color;
		logic        in_range;
	} rsp_t;

	typedef struct packed {
		logic [11:0] idx;
		logic [8:0]  data;
	} cfg_req_t;

	typedef struct packed {
		logic signed [13:0] x;
		logic signed [13:0] y;
		logic signed [13:0] w;
		logic signed [13:0] h;
		logic [15:0]        body;
		logic [15:0]        edge_col;
		logic               outlined;
	} rect_cmd_t;

	// One glyph row; 5 bits, leftmost pixel in bit 4.
	function automatic logic [4:0] font_row(input logic [7:0] code_in, input logic [2:0] row);
		logic [7:0]  c;
		logic [34:0] g;
		begin
			c = code_in;
			if (c >= 8'h61 && c <= 8'h7a)
				c = c - 8'h20;
			case (c)
				8'h20: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00};
				8'h41: g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
				8'h42: g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
				8'h43: g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
				8'h44: g = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
				8'h45: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
				8'h46: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
				8'h47: g = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F};
				8'h48: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
				8'h49: g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
				8'h4A: g = {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C};
				8'h4B: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
				8'h4C: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
				8'h4D: g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
				8'h4E: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
				8'h4F: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
				8'h50: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
				8'h51: g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
				8'h52: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
				8'h53: g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
				8'h54: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
				8'h55: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
				8'h56: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
				8'h57: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A};
				8'h58: g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
				8'h59: g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
				8'h5A: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
				8'h30: g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
				8'h31: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
				8'h32: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
				8'h33: g = {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E};
				8'h34: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
				8'h35: g = {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E};
				8'h36: g = {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E};
				8'h37: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
				8'h38: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
				8'h39: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C};
				8'h2E: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C};
				8'h2C: g = {5'h00,5'h00,5'h00,5'h00,5'h0C,5'h04,5'h08};
				8'h3A: g = {5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h00};
				8'h21: g = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04};
				8'h3F: g = {5'h0E,5'h11,5'h01,5'h06,5'h04,5'h00,5'h04};
				8'h2D: g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00};
				8'h2B: g = {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00};
				8'h3D: g = {5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00};
				8'h2F: g = {5'h01,5'h02,5'h02,5'h04,5'h08,5'h08,5'h10};
				8'h28: g = {5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02};
				8'h29: g = {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08};
				8'h5D: g = {5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E};
				8'h5B: g = {5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E};
				8'h3C: g = {5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02};
				8'h3E: g = {5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08};
				8'h5F: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F};
				8'h27: g = {5'h04,5'h04,5'h08,5'h00,5'h00,5'h00,5'h00};
				8'h22: g = {5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00};
				8'h2A: g = {5'h00,5'h0A,5'h04,5'h1F,5'h04,5'h0A,5'h00};
				8'h23: g = {5'h0A,5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h0A};
				8'h25: g = {5'h19,5'h1A,5'h02,5'h04,5'h08,5'h0B,5'h13};
				default: g = {5'h1F,5'h11,5'h11,5'h15,5'h11,5'h11,5'h1F};
			endcase
			case (row)
				3'd0: font_row = g[34:30];
				3'd1: font_row = g[29:25];
				3'd2: font_row = g[24:20];
				3'd3: font_row = g[19:15];
				3'd4: font_row = g[14:10];
				3'd5: font_row = g[9:5];
				default: font_row = g[4:0];
			endcase
		end
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_CELL,
		ST_RECT,
		ST_READ,
		ST_READ_WAIT,
		ST_READ_DATA,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		RS_IDLE,
		RS_ROW,
		RS_PIX
	} rstate_t;

	// Status of the rectangle walker back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} rect_sts_t;

endpackage

// ===== design/rag_rect_walker.sv =====
// ----------------------------------------------------------------------------
// rag_rect_walker
// Walks one clipped rectangle; one pixel write per cycle along each row.
// ----------------------------------------------------------------------------
module rag_rect_walker import rag_pkg::*; #(
	parameter int AW = 17
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rect_cmd_t          cmd,
	input  logic [12:0]        eff_w,
	input  logic [12:0]        eff_h,
	output rect_sts_t          sts,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [15:0]        wr_data
);

	rstate_t state_q, state_d;
	rect_cmd_t cmd_q;
	logic signed [14:0] x0_q, x1_q, y1_q, px_q, py_q;
	logic [AW-1:0] row_base_q, addr_q;

	logic signed [14:0] xe, ye, x0c, y0c, x1c, y1c;
	logic edge_hit;

	// clip bounds from the request; the walker itself uses the registered copy
	always_comb begin
		xe  = 15'(cmd.x) + 15'(cmd.w);
		ye  = 15'(cmd.y) + 15'(cmd.h);
		x0c = (cmd.x > 0) ? 15'(cmd.x) : '0;
		y0c = (cmd.y > 0) ? 15'(cmd.y) : '0;
		x1c = (xe < $signed({2'b00, eff_w})) ? xe : $signed({2'b00, eff_w});
		y1c = (ye < $signed({2'b00, eff_h})) ? ye : $signed({2'b00, eff_h});
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RS_IDLE: if (start) state_d = RS_ROW;
			RS_ROW:  state_d = (py_q < y1_q && x0_q < x1_q) ? RS_PIX : RS_IDLE;
			RS_PIX:  if (px_q + 15'sd1 >= x1_q) state_d = RS_ROW;
			default: state_d = RS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row_base tracks py*W by repeated add of the pitch
	always_ff @(posedge clk) begin
		unique case (state_q)
			RS_IDLE: if (start) begin
				cmd_q      <= cmd;
				x0_q       <= x0c;
				x1_q       <= x1c;
				y1_q       <= y1c;
				py_q       <= y0c;
				px_q       <= x0c;
				row_base_q <= AW'(AW'(y0c[12:0]) * AW'(eff_w));
			end
			RS_ROW: begin
				px_q   <= x0_q;
				addr_q <= row_base_q + AW'(x0_q[12:0]);
			end
			RS_PIX: begin
				px_q   <= px_q + 15'sd1;
				addr_q <= addr_q + AW'(1);
				if (px_q + 15'sd1 >= x1_q) begin
					py_q       <= py_q + 15'sd1;
					row_base_q <= row_base_q + AW'(eff_w);
				end
			end
			default: ;
		endcase
	end

	assign edge_hit = cmd_q.outlined && (px_q == 15'(cmd_q.x) || py_q == 15'(cmd_q.y)
		|| px_q == 15'(cmd_q.x) + 15'(cmd_q.w) - 15'sd1
		|| py_q == 15'(cmd_q.y) + 15'(cmd_q.h) - 15'sd1);

	always_comb begin
		wr_en   = (state_q == RS_PIX);
		wr_addr = addr_q;
		wr_data = edge_hit ? cmd_q.edge_col : cmd_q.body;
		sts.busy = (state_q != RS_IDLE);
		sts.done = (state_q == RS_ROW) && (state_d == RS_IDLE);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (px_q >= 0 && py_q >= 0 && px_q < $signed({2'b00, eff_w})))
		else $error("pixel write outside clipped area");
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> !sts.busy)
		else $error("walker busy after done");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == RS_IDLE) |=> sts.busy)
		else $error("walker did not start");

endmodule

// ===== design/rect_and_glyph_blitter.sv =====
// ----------------------------------------------------------------------------
// rect_and_glyph_blitter
// Framebuffer drawing engine: clear, fill, outlined fill, 5x7 glyph, read.
// ----------------------------------------------------------------------------
//  channel  | handshake       | payload
//  req      | req_valid/stall | req (req_t)
//  rsp      | rsp_valid/stall | rsp (rsp_t)
//  cfg      | cfg_valid/ready | cfg (cfg_req_t index + data)
//
// One pixel is written per cycle along a row; each rectangle row starts in a
// setup state. Clear writes all MAX_WIDTH*MAX_HEIGHT entries; a glyph walks
// up to 35 cells, drawing each lit cell as a rectangle at non-zero scale. A
// read passes ST_READ, ST_READ_WAIT and ST_READ_DATA before its response.
// Reset clears control only; the frame store is undefined until written.
// A new request is taken only after the previous response has left.
module rect_and_glyph_blitter import rag_pkg::*; #(
	parameter int MAX_WIDTH  = 320,
	parameter int MAX_HEIGHT = 240
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [11:0]      cfg_idx,
	input  logic [8:0]       cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	state_t state_q, state_d;
	req_t req_q;
	logic [8:0] sw_q;
	logic [7:0] sh_q;
	logic [12:0] eff_w, eff_h;
	logic [AW:0] clr_q;
	logic [2:0] row_q, col_q;
	logic [15:0] mem [DEPTH];
	logic [15:0] rd_q;
	logic ok_q;
	rsp_t rsp_q;

	rect_cmd_t rcmd;
	rect_sts_t rsts;
	logic r_start, r_wen;
	logic [AW-1:0] r_addr, rd_addr_q;
	logic [15:0] r_data;
	logic [4:0] glyph_row;
	logic lit, last_cell;
	logic [11:0] ea, eb, fa, fb;

	assign eff_w = (13'(sw_q) < 13'(MAX_WIDTH))  ? 13'(sw_q) : 13'(MAX_WIDTH);
	assign eff_h = (13'(sh_q) < 13'(MAX_HEIGHT)) ? 13'(sh_q) : 13'(MAX_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= 9'd320;
			sh_q <= 8'd240;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_idx == 12'(CFG_WIDTH))  sw_q <= cfg_data;
			if (cfg_idx == 12'(CFG_HEIGHT)) sh_q <= cfg_data[7:0];
		end
	end
	assign cfg_ready = 1'b1;

	// cell edges: round(i*scale) = (i*scale+8)>>4
	assign ea = 12'((16'(col_q) * 16'(req_q.scale_q4) + 16'd8) >> 4);
	assign eb = 12'(((16'(col_q) + 16'd1) * 16'(req_q.scale_q4) + 16'd8) >> 4);
	assign fa = 12'((16'(row_q) * 16'(req_q.scale_q4) + 16'd8) >> 4);
	assign fb = 12'(((16'(row_q) + 16'd1) * 16'(req_q.scale_q4) + 16'd8) >> 4);
	assign glyph_row = font_row(req_q.char_code, row_q);
	assign lit = glyph_row[3'd4 - col_q];
	assign last_cell = (col_q == 3'(GLYPH_COLS - 1)) && (row_q == 3'(GLYPH_ROWS - 1));

	always_comb begin
		rcmd.outlined = (state_q == ST_IDLE) && (req.kind == KIND_FRAME);
		rcmd.body     = (state_q == ST_IDLE) ? req.color : req_q.color;
		rcmd.edge_col = req.outline_color;
		if (state_q == ST_IDLE) begin
			rcmd.x = 14'(req.pos_x);
			rcmd.y = 14'(req.pos_y);
			rcmd.w = 14'({1'b0, req.rect_w});
			rcmd.h = 14'({1'b0, req.rect_h});
		end else begin
			rcmd.x = 14'(req_q.pos_x) + 14'({1'b0, ea});
			rcmd.y = 14'(req_q.pos_y) + 14'({1'b0, fa});
			rcmd.w = 14'({1'b0, eb}) - 14'({1'b0, ea});
			rcmd.h = 14'({1'b0, fb}) - 14'({1'b0, fa});
		end
		r_start = ((state_q == ST_IDLE) && req_valid && !req_stall
			&& (req.kind == KIND_FILL || req.kind == KIND_FRAME))
			|| ((state_q == ST_CELL) && lit && req_q.scale_q4 != 8'd0);
	end

	rag_rect_walker #(.AW(AW)) u_walk (
		.clk(clk), .arst_n(arst_n), .start(r_start), .cmd(rcmd),
		.eff_w(eff_w), .eff_h(eff_h), .sts(rsts),
		.wr_en(r_wen), .wr_addr(r_addr), .wr_data(r_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid && !req_stall) begin
				unique case (req.kind)
					KIND_CLEAR: state_d = ST_CLEAR;
					KIND_FILL, KIND_FRAME: state_d = ST_RECT;
					KIND_GLYPH: state_d = ST_CELL;
					KIND_READ: state_d = ST_READ;
					default: state_d = ST_RESP;
				endcase
			end
			ST_CLEAR: if (clr_q == (AW+1)'(DEPTH - 1)) state_d = ST_RESP;
			ST_CELL: state_d = r_start ? ST_RECT : (last_cell ? ST_RESP : ST_CELL);
			ST_RECT: if (rsts.done)
				state_d = (req_q.kind == KIND_GLYPH && !last_cell) ? ST_CELL : ST_RESP;
			ST_READ: state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_READ_DATA;
			ST_READ_DATA: state_d = ST_RESP;
			ST_RESP: if (!rsp_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		rsp_valid = (state_q == ST_RESP);
		rsp       = rsp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
			clr_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end
		if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		// advance cell when leaving it, either skipped or drawn
		if ((state_q == ST_CELL && !r_start && !last_cell)
			|| (state_q == ST_RECT && rsts.done && req_q.kind == KIND_GLYPH)) begin
			if (col_q == 3'(GLYPH_COLS - 1)) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
			end else begin
				col_q <= col_q + 3'd1;
			end
		end
		if (state_q == ST_READ) begin
			ok_q <= req_q.pos_x >= 0 && req_q.pos_y >= 0
				&& 13'(req_q.pos_x[10:0]) < eff_w && req_q.pos_x < 12'sd2047
				&& $signed({1'b0, eff_w}) > 14'(req_q.pos_x)
				&& $signed({1'b0, eff_h}) > 14'(req_q.pos_y);
			rd_addr_q <= AW'(AW'(req_q.pos_y[10:0]) * AW'(eff_w) + AW'(req_q.pos_x[10:0]));
		end
		// rd_q holds the addressed pixel from the cycle after the address settles
		if (state_q == ST_READ_DATA) begin
			rsp_q.read_color <= ok_q ? rd_q : 16'd0;
			rsp_q.in_range   <= ok_q;
		end else if (state_q != ST_RESP && state_d == ST_RESP) begin
			rsp_q <= '0;
		end
	end

	// frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			mem[clr_q[AW-1:0]] <= req_q.color;
		else if (r_wen)
			mem[r_addr] <= r_data;
		rd_q <= mem[rd_addr_q];
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while response pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> rsp_valid)
		else $error("response dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !r_wen)
		else $error("write port conflict");

endmodule

// ===== bench/rag_scoreboard.sv =====
// ----------------------------------------------------------------------------
// rag_scoreboard
// Checker for the blitter: watches the request, response and config
// channels, keeps a shadow frame store, predicts each response and compares.
// ----------------------------------------------------------------------------
module rag_scoreboard import rag_pkg::*; #(
	parameter int MAX_WIDTH  = 320,
	parameter int MAX_HEIGHT = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [11:0] cfg_idx,
	input  logic [8:0]  cfg_data,
	output int          errors,
	output int          pending
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

	logic [15:0] shadow_fb [DEPTH];
	logic [34:0] font_tbl [256];
	logic [8:0]  sh_width;
	logic [7:0]  sh_height;
	rsp_t        rsp_expected [$];

	initial begin
		errors = 0;
		pending = 0;
		for (int i = 0; i < 256; i++)
			font_tbl[i] = {5'h1F, 5'h11, 5'h11, 5'h15, 5'h11, 5'h11, 5'h1F};
		font_tbl[8'h20] = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
		font_tbl["A"] = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
		font_tbl["B"] = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
		font_tbl["C"] = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
		font_tbl["D"] = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
		font_tbl["E"] = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
		font_tbl["F"] = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
		font_tbl["G"] = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
		font_tbl["H"] = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
		font_tbl["I"] = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
		font_tbl["J"] = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
		font_tbl["K"] = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
		font_tbl["L"] = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
		font_tbl["M"] = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
		font_tbl["N"] = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
		font_tbl["O"] = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
		font_tbl["P"] = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
		font_tbl["Q"] = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
		font_tbl["R"] = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
		font_tbl["S"] = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
		font_tbl["T"] = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
		font_tbl["U"] = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
		font_tbl["V"] = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
		font_tbl["W"] = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
		font_tbl["X"] = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
		font_tbl["Y"] = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
		font_tbl["Z"] = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
		font_tbl["0"] = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
		font_tbl["1"] = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
		font_tbl["2"] = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
		font_tbl["3"] = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
		font_tbl["4"] = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
		font_tbl["5"] = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
		font_tbl["6"] = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
		font_tbl["7"] = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
		font_tbl["8"] = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
		font_tbl["9"] = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
		font_tbl["."] = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
		font_tbl[","] = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h04, 5'h08};
		font_tbl[":"] = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
		font_tbl["!"] = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
		font_tbl[8'd63] = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h04, 5'h00, 5'h04};
		font_tbl["-"] = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
		font_tbl["+"] = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
		font_tbl["="] = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
		font_tbl["/"] = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
		font_tbl["("] = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
		font_tbl[")"] = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
		font_tbl["]"] = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
		font_tbl["["] = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
		font_tbl["<"] = {5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02};
		font_tbl[">"] = {5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08};
		font_tbl["_"] = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
		font_tbl[8'd39] = {5'h04, 5'h04, 5'h08, 5'h00, 5'h00, 5'h00, 5'h00};
		font_tbl[8'd34] = {5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
		font_tbl["*"] = {5'h00, 5'h0A, 5'h04, 5'h1F, 5'h04, 5'h0A, 5'h00};
		font_tbl["#"] = {5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h0A};
		font_tbl["%"] = {5'h19, 5'h1A, 5'h02, 5'h04, 5'h08, 5'h0B, 5'h13};
	end

	function automatic int active_w();
		return (sh_width < MAX_WIDTH) ? int'(sh_width) : MAX_WIDTH;
	endfunction

	function automatic int active_h();
		return (sh_height < MAX_HEIGHT) ? int'(sh_height) : MAX_HEIGHT;
	endfunction

	function automatic void paint(input int x, input int y, input int w, input int h,
			input logic [15:0] body, input logic [15:0] border, input bit outlined);
		int wa, ha, x0, y0, x1, y1, ix;
		bit on_edge;
		wa = active_w();
		ha = active_h();
		x0 = (x > 0) ? x : 0;
		y0 = (y > 0) ? y : 0;
		x1 = (x + w < wa) ? x + w : wa;
		y1 = (y + h < ha) ? y + h : ha;
		for (int py = y0; py < y1; py++)
			for (int px = x0; px < x1; px++) begin
				on_edge = outlined && (px == x || py == y || px == x + w - 1 || py == y + h - 1);
				ix = py * wa + px;
				if (ix < DEPTH)
					shadow_fb[ix] = on_edge ? border : body;
			end
	endfunction

	function automatic void draw_char(input int x, input int y, input logic [7:0] code,
			input logic [15:0] col, input int sc);
		logic [7:0]  c;
		logic [34:0] bits;
		int xa, xb, ya, yb;
		c = code;
		if (c >= "a" && c <= "z")
			c = c - 8'h20;
		bits = font_tbl[c];
		for (int r = 0; r < GLYPH_ROWS; r++)
			for (int k = 0; k < GLYPH_COLS; k++)
				if (bits[34 - r * GLYPH_COLS - k]) begin
					xa = x + ((k * sc + 8) >>> 4);
					xb = x + (((k + 1) * sc + 8) >>> 4);
					ya = y + ((r * sc + 8) >>> 4);
					yb = y + (((r + 1) * sc + 8) >>> 4);
					paint(xa, ya, xb - xa, yb - ya, col, col, 1'b0);
				end
	endfunction

	function automatic rsp_t execute(input req_t q);
		rsp_t res;
		int   x, y;
		res = '0;
		x = int'(q.pos_x);
		y = int'(q.pos_y);
		case (q.kind)
			KIND_CLEAR: for (int i = 0; i < DEPTH; i++) shadow_fb[i] = q.color;
			KIND_FILL:  paint(x, y, int'(q.rect_w), int'(q.rect_h), q.color, q.color, 1'b0);
			KIND_FRAME: paint(x, y, int'(q.rect_w), int'(q.rect_h), q.color,
					q.outline_color, 1'b1);
			KIND_GLYPH: draw_char(x, y, q.char_code, q.color, int'(q.scale_q4));
			KIND_READ:
				if (x >= 0 && y >= 0 && x < active_w() && y < active_h()) begin
					res.read_color = shadow_fb[y * active_w() + x];
					res.in_range = 1'b1;
				end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			sh_width <= 9'd320;
			sh_height <= 8'd240;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_idx == 12'(CFG_WIDTH))
					sh_width <= cfg_data;
				else if (cfg_idx == 12'(CFG_HEIGHT))
					sh_height <= cfg_data[7:0];
			end
			if (req_valid && !req_stall)
				rsp_expected.push_back(execute(req));
			if (rsp_valid && !rsp_stall) begin
				if (rsp_expected.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response %h", rsp);
				end else begin
					want = rsp_expected.pop_front();
					if (want.read_color !== rsp.read_color || want.in_range !== rsp.in_range) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected color %h in_range %b, got %h %b",
								want.read_color, want.in_range, rsp.read_color, rsp.in_range);
					end
				end
			end
			pending = rsp_expected.size();
		end
	end

endmodule

// ===== bench/rect_and_glyph_blitter_tb.sv =====
// ----------------------------------------------------------------------------
// rect_and_glyph_blitter_tb
// Drives clear, fill, outlined fill, glyph and read requests through several
// surface sizes with random idling and back-pressure; the scoreboard checks.
// ----------------------------------------------------------------------------
module rect_and_glyph_blitter_tb import rag_pkg::*;;

	localparam int LIMIT = 4000000;
	localparam int PER_PHASE = 70;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [11:0] cfg_idx = '0;
	logic [8:0]  cfg_data = '0;
	int          errors, pending;
	int          cycles = 0;
	int          rsp_seen = 0;
	int          hold_left = 0;
	bit          hold_done = 0;
	int          cur_w = 320, cur_h = 240;

	always #5 clk = ~clk;

	rect_and_glyph_blitter uut (.*);

	rag_scoreboard scb (.*);

	function automatic bit quiet();
		return rsp_seen >= 200 && rsp_seen < 300;
	endfunction

	// Receiver: random stalls, one long hold-off once the run is under way.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (rsp_valid && !rsp_stall)
			rsp_seen <= rsp_seen + 1;
		if (!hold_done && rsp_seen == 60) begin
			hold_done <= 1;
			hold_left <= 400;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= !quiet() && $urandom_range(99) < 20;
	end

	task automatic send(input req_t r);
		while (!quiet() && $urandom_range(99) < 20) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic set_reg(input logic [11:0] idx, input logic [8:0] val);
		cfg_idx <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic req_t cmd(input kind_t k, input int x, input int y, input int w,
			input int h, input logic [7:0] ch, input logic [15:0] col,
			input logic [15:0] ocol, input logic [7:0] sc);
		req_t r;
		r.kind = k;
		r.pos_x = 12'(x);
		r.pos_y = 12'(y);
		r.rect_w = 12'(w);
		r.rect_h = 12'(h);
		r.char_code = ch;
		r.color = col;
		r.outline_color = ocol;
		r.scale_q4 = sc;
		return r;
	endfunction

	function automatic req_t rand_cmd();
		req_t r;
		int   sel;
		r.char_code = 8'($urandom);
		r.color = 16'($urandom);
		r.outline_color = 16'($urandom);
		r.scale_q4 = 8'($urandom);
		r.pos_x = 12'($urandom_range(cur_w + 12) - 8);
		r.pos_y = 12'($urandom_range(cur_h + 12) - 8);
		r.rect_w = 12'($urandom_range(24));
		r.rect_h = 12'($urandom_range(24));
		sel = $urandom_range(99);
		if (sel < 25)
			r.kind = KIND_FILL;
		else if (sel < 50)
			r.kind = KIND_FRAME;
		else if (sel < 72)
			r.kind = KIND_GLYPH;
		else if (sel < 95)
			r.kind = KIND_READ;
		else
			r.kind = 3'($urandom_range(7, 5));
		sel = $urandom_range(99);
		if (sel < 10) begin
			r.pos_x = 12'($urandom);
			r.pos_y = 12'($urandom);
		end
		if (r.kind == KIND_FILL || r.kind == KIND_FRAME) begin
			if (sel >= 85 && sel < 93) begin
				r.rect_w = 12'($urandom);
				r.rect_h = 12'($urandom_range(2));
			end else if (sel >= 93) begin
				r.rect_h = 12'($urandom);
				r.rect_w = 12'($urandom_range(2));
			end
		end
		// big scales are slow, keep them rare
		if (r.kind == KIND_GLYPH && sel < 85)
			r.scale_q4 = 8'($urandom_range(40));
		return r;
	endfunction

	initial begin
		int ws [6] = '{320, 1, 0, 511, 17, 300};
		int hs [6] = '{240, 1, 0, 255, 9, 238};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0));
		send(cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_FILL, 0, 0, 0, 5, 0, 16'h1234, 0, 0));
		send(cmd(KIND_FILL, -2048, -2048, 4095, 2050, 0, 16'h0000, 0, 0));
		send(cmd(KIND_FILL, 100, -2048, 1, 4095, 0, 16'hA5A5, 0, 0));
		send(cmd(KIND_FRAME, -3, -3, 10, 10, 0, 16'h1111, 16'h2222, 0));
		send(cmd(KIND_FRAME, 5, 5, 6, 4, 0, 16'h3333, 16'hFFFF, 0));
		send(cmd(KIND_FRAME, 310, 230, 20, 20, 0, 16'h4444, 16'h5555, 0));
		send(cmd(KIND_GLYPH, 10, 10, 0, 0, "a", 16'h7777, 0, 16));
		send(cmd(KIND_GLYPH, 40, 10, 0, 0, "A", 16'h8888, 0, 24));
		send(cmd(KIND_GLYPH, 60, 10, 0, 0, 8'h80, 16'h9999, 0, 16));
		send(cmd(KIND_GLYPH, 80, 10, 0, 0, "Z", 16'hAAAA, 0, 0));
		send(cmd(KIND_GLYPH, 90, 10, 0, 0, " ", 16'hBBBB, 0, 16));
		send(cmd(KIND_GLYPH, 300, 220, 0, 0, "%", 16'hCCCC, 0, 255));
		send(cmd(KIND_READ, 10, 10, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_READ, 12, 10, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_READ, 319, 239, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_READ, 320, 0, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_READ, -1, 5, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_READ, 2047, 2047, 0, 0, 0, 0, 0, 0));
		send(cmd(kind_t'(3'd5), 0, 0, 0, 0, 0, 16'hFFFF, 0, 0));
		send(cmd(kind_t'(3'd7), 1, 1, 1, 1, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));

		for (int p = 0; p < 6; p++) begin
			drain();
			cur_w = (ws[p] < 320) ? ws[p] : 320;
			cur_h = (hs[p] < 240) ? hs[p] : 240;
			set_reg(12'(CFG_WIDTH), 9'(ws[p]));
			set_reg(12'(CFG_HEIGHT), 9'(hs[p]));
			if (p == 4)
				send(cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 16'($urandom), 0, 0));
			for (int i = 0; i < PER_PHASE; i++)
				send(rand_cmd());
		end
		drain();

		$display("Covered %0d responses over six surface sizes, incl. empty and oversized.",
			rsp_seen);
		$display("Fill, outline, glyph, read and unused kinds, with stalls and a long hold.");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
